/* rtl/core/sia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg: shared types and constants of the signed integer ALU
// Operation codes, field widths and the control word that travels down the
// pipeline next to the data.
// ----------------------------------------------------------------------------
package sia_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned FIELD_W  = 64;
  localparam int unsigned MODE_W   = 3;

  // Default working word width
  localparam int unsigned WORD_WIDTH_DEF = 64;

  // Operation codes; code 7 is unused and yields zero
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_MOD  = 3'd4,
    MODE_CMP  = 3'd5,
    MODE_MOVE = 3'd6
  } mode_e;

  // Control word carried along with every request
  typedef struct packed {
    mode_e mode;
    logic  neg_q;  // quotient must be negated
    logic  neg_r;  // remainder must be negated
    logic  dz;     // divide or remainder by zero
  } ctl_t;

endpackage

/* rtl/core/sia_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_in_if: operation request channel
// Valid/ready channel that carries the operation code and both operands.
// ----------------------------------------------------------------------------
interface sia_in_if import sia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [FIELD_W-1:0]  operand_a;
  logic [FIELD_W-1:0]  operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

/* rtl/core/sia_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_out_if: result channel
// Valid/ready channel that carries the result and the divide-by-zero flag.
// ----------------------------------------------------------------------------
interface sia_out_if import sia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  result;
  logic                divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

/* rtl/core/signed_integer_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_alu: pipelined signed integer ALU with divide
// Add, subtract, multiply, divide, remainder, compare and move on signed
// words of WORD_WIDTH bits, results sign-extended to 64 bits.
// ----------------------------------------------------------------------------
// The unit accepts one request every clock cycle while the pipeline is not
// full and stalled, and returns results in request order through two
// preparation stages, one divider cell per quotient bit, and the output
// register. Every operation runs through the whole row of divider cells,
// so the latency is the same for all codes. Each stage advances on its
// own, so empty slots close up while the output is stalled and requests
// are still taken until the pipeline is full.
// Divide or remainder by zero gives 0 with divide_by_zero set; the minimum
// value divided by -1 wraps to the minimum with remainder 0.
// ----------------------------------------------------------------------------
module signed_integer_alu import sia_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sia_in_if.sink     in_i,
  sia_out_if.source  out_o
);

  localparam int unsigned W = WORD_WIDTH;

  logic         v   [0:W];
  logic         r   [0:W];
  ctl_t         ctl [0:W];
  logic [W-1:0] res [0:W];
  logic [W-1:0] dvd [0:W];
  logic [W-1:0] rem [0:W];
  logic [W-1:0] dvs [0:W];
  logic [W-1:0] out_res;

  // Operand preparation
  sia_prep #(.W(W)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .mode_i  (in_i.mode),
    .a_i     (in_i.operand_a[W-1:0]),
    .b_i     (in_i.operand_b[W-1:0]),
    .valid_o (v[0]),
    .ready_i (r[0]),
    .ctl_o   (ctl[0]),
    .res_o   (res[0]),
    .dvd_o   (dvd[0]),
    .dvs_o   (dvs[0])
  );

  assign rem[0] = '0;

  // Row of divider cells, one quotient bit each
  for (genvar k = 0; k < W; k++) begin : g_cell
    sia_div_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (r[k]),
      .ctl_i   (ctl[k]),
      .res_i   (res[k]),
      .dvd_i   (dvd[k]),
      .rem_i   (rem[k]),
      .dvs_i   (dvs[k]),
      .valid_o (v[k+1]),
      .ready_i (r[k+1]),
      .ctl_o   (ctl[k+1]),
      .res_o   (res[k+1]),
      .dvd_o   (dvd[k+1]),
      .rem_o   (rem[k+1]),
      .dvs_o   (dvs[k+1])
    );
  end

  // Sign fix-up and output register
  sia_post #(.W(W)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v[W]),
    .ready_o (r[W]),
    .ctl_i   (ctl[W]),
    .res_i   (res[W]),
    .quo_i   (dvd[W]),
    .rem_i   (rem[W]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res),
    .dz_o    (out_o.divide_by_zero)
  );

  assign out_o.result = FIELD_W'($signed(out_res));

  // Divide by zero always carries a zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_by_zero |-> out_o.result == '0)
    else $error("divide by zero with nonzero result");

  // Requests are refused only when the whole pipeline is full and stalled
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready && v[W] && v[0])
    else $error("request refused with room in pipeline");

  // Leaving the last cell, the remainder is below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v[W] && !ctl[W].dz &&
    (ctl[W].mode == MODE_DIV || ctl[W].mode == MODE_MOD) |-> rem[W] < dvs[W])
    else $error("remainder not below divisor");

  // The zero flag only comes with divide or remainder
  a_dz_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v[W] && ctl[W].dz |-> ctl[W].mode == MODE_DIV || ctl[W].mode == MODE_MOD)
    else $error("zero flag on wrong operation");

endmodule

/* rtl/core/sia_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_prep: operand preparation stages
// Stage 0 does add, subtract, compare and move, takes the operand magnitudes
// and forms the multiply partial products. Stage 1 sums the partial products
// and sets up the dividend for the divider cells.
// ----------------------------------------------------------------------------
module sia_prep import sia_pkg::*; #(
  parameter int unsigned W = WORD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ctl_t              ctl_o,
  output logic [W-1:0]      res_o,
  output logic [W-1:0]      dvd_o,
  output logic [W-1:0]      dvs_o
);

  localparam int unsigned LO = W / 2;
  localparam int unsigned HI = W - LO;

  mode_e           mode;
  logic [W-1:0]    res0_d;
  logic [W-1:0]    mag_a, mag_b;
  logic [W-1:0]    p_lh, p_hl;
  logic [2*LO-1:0] p_ll;
  ctl_t            ctl0_d;

  logic            v0_q, v1_q;
  ctl_t            ctl0_q, ctl1_q;
  logic [W-1:0]    res0_q, res1_q;
  logic [W-1:0]    ma0_q, mb0_q, dvd1_q, dvs1_q;
  logic [2*LO-1:0] pll_q;
  logic [HI-1:0]   plh_q, phl_q;
  logic            rdy0, rdy1;

  assign mode = mode_e'(mode_i);

  // Add, subtract, compare and move
  always_comb begin
    unique case (mode)
      MODE_ADD:  res0_d = a_i + b_i;
      MODE_SUB:  res0_d = a_i - b_i;
      MODE_CMP: begin
        if (a_i == b_i) begin
          res0_d = '0;
        end else if ($signed(a_i) < $signed(b_i)) begin
          res0_d = '1;
        end else begin
          res0_d = W'(1);
        end
      end
      MODE_MOVE: res0_d = a_i;
      default:   res0_d = '0;
    endcase
  end

  // Magnitudes; the minimum maps to itself, read as unsigned
  assign mag_a = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  always_comb begin
    ctl0_d.mode  = mode;
    ctl0_d.neg_q = a_i[W-1] ^ b_i[W-1];
    ctl0_d.neg_r = a_i[W-1];
    ctl0_d.dz    = ((mode == MODE_DIV) || (mode == MODE_MOD)) && (b_i == '0);
  end

  // Partial products of the low half of the product
  assign p_ll = {{LO{1'b0}}, a_i[LO-1:0]} * {{LO{1'b0}}, b_i[LO-1:0]};
  assign p_lh = {{HI{1'b0}}, a_i[LO-1:0]} * {{LO{1'b0}}, b_i[W-1:LO]};
  assign p_hl = {{LO{1'b0}}, a_i[W-1:LO]} * {{HI{1'b0}}, b_i[LO-1:0]};

  // Stage advance
  assign rdy1    = !v1_q || ready_i;
  assign rdy0    = !v0_q || rdy1;
  assign ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= valid_i;
      if (rdy1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      ctl0_q <= ctl0_d;
      res0_q <= res0_d;
      ma0_q  <= mag_a;
      mb0_q  <= mag_b;
      pll_q  <= p_ll;
      plh_q  <= p_lh[HI-1:0];
      phl_q  <= p_hl[HI-1:0];
    end
    if (rdy1) begin
      ctl1_q <= ctl0_q;
      res1_q <= (ctl0_q.mode == MODE_MUL)
              ? (W'(pll_q) + {plh_q + phl_q, {LO{1'b0}}}) : res0_q;
      dvd1_q <= ma0_q;
      dvs1_q <= mb0_q;
    end
  end

  assign valid_o = v1_q;
  assign ctl_o   = ctl1_q;
  assign res_o   = res1_q;
  assign dvd_o   = dvd1_q;
  assign dvs_o   = dvs1_q;

endmodule

/* rtl/core/sia_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_div_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the dividend word.
// ----------------------------------------------------------------------------
module sia_div_cell import sia_pkg::*; #(
  parameter int unsigned W = WORD_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  ctl_t         ctl_i,
  input  logic [W-1:0] res_i,
  input  logic [W-1:0] dvd_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] dvs_i,
  output logic         valid_o,
  input  logic         ready_i,
  output ctl_t         ctl_o,
  output logic [W-1:0] res_o,
  output logic [W-1:0] dvd_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] dvs_o
);

  logic [W:0]   shifted, trial;
  logic [W-1:0] rem_d;
  logic         q_bit, rdy;
  logic         v_q;
  ctl_t         ctl_q;
  logic [W-1:0] res_q, dvd_q, rem_q, dvs_q;

  // Trial subtraction
  assign shifted = {rem_i, dvd_i[W-1]};
  assign trial   = shifted - {1'b0, dvs_i};
  assign q_bit   = !trial[W];
  assign rem_d   = q_bit ? trial[W-1:0] : shifted[W-1:0];

  assign rdy     = !v_q || ready_i;
  assign ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      ctl_q <= ctl_i;
      res_q <= res_i;
      dvd_q <= {dvd_i[W-2:0], q_bit};
      rem_q <= rem_d;
      dvs_q <= dvs_i;
    end
  end

  assign valid_o = v_q;
  assign ctl_o   = ctl_q;
  assign res_o   = res_q;
  assign dvd_o   = dvd_q;
  assign rem_o   = rem_q;
  assign dvs_o   = dvs_q;

endmodule

/* rtl/core/sia_post.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_post: result selection and output register
// Applies the signs to quotient and remainder, zeroes a divide by zero and
// holds the finished result for the output channel.
// ----------------------------------------------------------------------------
module sia_post import sia_pkg::*; #(
  parameter int unsigned W = WORD_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  ctl_t         ctl_i,
  input  logic [W-1:0] res_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] rem_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] res_o,
  output logic         dz_o
);

  logic [W-1:0] res_d;
  logic         rdy, v_q, dz_q;
  logic [W-1:0] res_q;

  // Final result select
  always_comb begin
    if (ctl_i.dz) begin
      res_d = '0;
    end else if (ctl_i.mode == MODE_DIV) begin
      res_d = ctl_i.neg_q ? (W'(0) - quo_i) : quo_i;
    end else if (ctl_i.mode == MODE_MOD) begin
      res_d = ctl_i.neg_r ? (W'(0) - rem_i) : rem_i;
    end else begin
      res_d = res_i;
    end
  end

  assign rdy     = !v_q || ready_i;
  assign ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      res_q <= res_d;
      dz_q  <= ctl_i.dz;
    end
  end

  assign valid_o = v_q;
  assign res_o   = res_q;
  assign dz_o    = dz_q;

endmodule
